/* rtl/trie_dictionary_engine_macros.svh */
// Assertion macros shared by the trie dictionary engine RTL.
`ifndef TRIE_DICTIONARY_ENGINE_MACROS_SVH
`define TRIE_DICTIONARY_ENGINE_MACROS_SVH

`ifndef SYNTHESIS

// Implication checked on every rising clock edge outside reset.
`define TDE_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("trie engine implication check failed");

// Implication whose consequence is checked in the cycle after the antecedent.
`define TDE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("trie engine next-cycle check failed");

// Condition that must hold on every rising clock edge outside reset.
`define TDE_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("trie engine invariant failed");

`else

`define TDE_ASSERT_IMP(label, ante, cons)
`define TDE_ASSERT_NEXT(label, ante, cons)
`define TDE_ASSERT_ALWAYS(label, cond)

`endif

`endif

/* rtl/tde_pkg.sv */
// Shared types and constants of the trie dictionary engine.
package tde_pkg;

  localparam int REQ_W    = 2;
  localparam int LETTER_W = 5;

  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd1;
  localparam logic [REQ_W-1:0] REQ_PREFIX = 2'd2;

  typedef struct packed {
    logic found;
    logic table_full;
  } tde_result_t;

endpackage

/* rtl/tde_ram.sv */
// Simple dual-port synchronous RAM with registered read.
module tde_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 10,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/trie_dictionary_engine.sv */
// Trie dictionary engine: one letter per transfer, results on the last letter.
// The result strobe is registered from the S_LINK state, or from the S_MARK state for
// an exact search (word-end mark read). A new letter is taken only once the previous
// one is through its child-link table read; the receiver cannot stall. After reset a
// clearing sweep over all NODE_COUNT*ALPHABET_SIZE link entries (26624 by default)
// holds busy high.
module trie_dictionary_engine #(
  parameter int NODE_COUNT    = 1024,
  parameter int ALPHABET_SIZE = 26
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [tde_pkg::REQ_W-1:0]     in_req_type,
  input  logic [tde_pkg::LETTER_W-1:0]  in_letter,
  input  logic                          in_last_letter,
  output logic                          out_valid,
  output logic                          out_found,
  output logic                          out_table_full
);

  import tde_pkg::*;

  `include "trie_dictionary_engine_macros.svh"

  localparam int NODE_W     = $clog2(NODE_COUNT);
  localparam int LINK_DEPTH = NODE_COUNT * ALPHABET_SIZE;
  localparam int LINK_AW    = $clog2(LINK_DEPTH);

  localparam logic [NODE_W:0]     NODE_LIMIT  = (NODE_W+1)'(NODE_COUNT);
  localparam logic [8:0]          ALPHA_LIMIT = 9'(ALPHABET_SIZE);
  localparam logic [LINK_AW-1:0]  CLEAR_LAST  = LINK_AW'(LINK_DEPTH - 1);
  localparam logic [LINK_AW:0]    MARK_LIMIT  = (LINK_AW+1)'(NODE_COUNT);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LINK = 2'd1;
  localparam logic [1:0] S_MARK = 2'd2;

  logic [1:0]          state_r, state_nxt;
  logic [NODE_W-1:0]   cursor_r, cursor_nxt;
  logic [NODE_W:0]     next_free_r, next_free_nxt;
  logic                missed_r, missed_nxt;
  logic                overflow_r, overflow_nxt;
  logic [REQ_W-1:0]    req_r, req_nxt;
  logic                last_r, last_nxt;
  logic                live_r, live_nxt;
  logic [LINK_AW-1:0]  slot_r, slot_nxt;
  logic                clear_active_r;
  logic [LINK_AW-1:0]  clear_addr_r;
  logic                out_valid_r, out_valid_nxt;
  tde_result_t         result_r, result_nxt;

  logic                accept;
  logic                item_ok;
  logic [LINK_AW-1:0]  slot_addr;

  logic                link_we;
  logic [LINK_AW-1:0]  link_waddr;
  logic [NODE_W-1:0]   link_wdata;
  logic                link_re;
  logic [NODE_W-1:0]   link_rdata;

  logic                mark_we;
  logic [NODE_W-1:0]   mark_waddr;
  logic                mark_wdata;
  logic                mark_re;
  logic [NODE_W-1:0]   mark_raddr;
  logic                mark_rdata;

  logic                alloc_we;
  logic                end_we;
  logic [NODE_W-1:0]   child;

  assign busy   = clear_active_r || (state_r != S_IDLE);
  assign accept = start && !busy;

  assign item_ok = (in_req_type == REQ_INSERT || in_req_type == REQ_SEARCH ||
                    in_req_type == REQ_PREFIX) &&
                   ({4'b0, in_letter} < ALPHA_LIMIT);

  assign slot_addr = LINK_AW'(cursor_r) * LINK_AW'(ALPHABET_SIZE) + LINK_AW'(in_letter);

  always_comb begin
    state_nxt     = state_r;
    cursor_nxt    = cursor_r;
    next_free_nxt = next_free_r;
    missed_nxt    = missed_r;
    overflow_nxt  = overflow_r;
    req_nxt       = req_r;
    last_nxt      = last_r;
    live_nxt      = live_r;
    slot_nxt      = slot_r;
    out_valid_nxt = 1'b0;
    result_nxt    = result_r;
    link_re       = 1'b0;
    alloc_we      = 1'b0;
    end_we        = 1'b0;
    mark_re       = 1'b0;
    child         = link_rdata;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          req_nxt   = in_req_type;
          last_nxt  = in_last_letter;
          slot_nxt  = slot_addr;
          live_nxt  = !missed_r && !overflow_r && item_ok;
          link_re   = !missed_r && !overflow_r && item_ok;
          if (!missed_r && !overflow_r && !item_ok) begin
            missed_nxt = 1'b1;
          end
          state_nxt = S_LINK;
        end
      end
      S_LINK: begin
        state_nxt           = S_IDLE;
        result_nxt.found      = 1'b0;
        if (live_r) begin
          if (link_rdata == '0 && req_r == REQ_INSERT) begin
            if (next_free_r < NODE_LIMIT) begin
              child         = next_free_r[NODE_W-1:0];
              next_free_nxt = next_free_r + {{NODE_W{1'b0}}, 1'b1};
              alloc_we      = 1'b1;
            end else begin
              overflow_nxt = 1'b1;
            end
          end
          if (!overflow_nxt) begin
            if (child == '0) begin
              missed_nxt = 1'b1;
            end else begin
              cursor_nxt = child;
              if (last_r) begin
                if (req_r == REQ_INSERT) begin
                  end_we           = 1'b1;
                  result_nxt.found = 1'b1;
                end else if (req_r == REQ_SEARCH) begin
                  mark_re   = 1'b1;
                  state_nxt = S_MARK;
                end else begin
                  result_nxt.found = 1'b1;
                end
              end
            end
          end
        end
        result_nxt.table_full = (req_r == REQ_INSERT) && overflow_nxt;
        if (last_r && state_nxt == S_IDLE) begin
          out_valid_nxt = 1'b1;
          cursor_nxt    = '0;
          missed_nxt    = 1'b0;
          overflow_nxt  = 1'b0;
        end
      end
      S_MARK: begin
        // Exact search: the word-end mark of the final node decides.
        state_nxt             = S_IDLE;
        out_valid_nxt         = 1'b1;
        result_nxt.found      = mark_rdata;
        result_nxt.table_full = 1'b0;
        cursor_nxt            = '0;
        missed_nxt            = 1'b0;
        overflow_nxt          = 1'b0;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // The clearing sweep owns both write ports until it ends.
  always_comb begin
    if (clear_active_r) begin
      link_we    = 1'b1;
      link_waddr = clear_addr_r;
      link_wdata = '0;
      mark_we    = ({1'b0, clear_addr_r} < MARK_LIMIT);
      mark_waddr = clear_addr_r[NODE_W-1:0];
      mark_wdata = 1'b0;
    end else begin
      link_we    = alloc_we;
      link_waddr = slot_r;
      link_wdata = child;
      mark_we    = end_we;
      mark_waddr = child;
      mark_wdata = 1'b1;
    end
  end

  assign mark_raddr = child;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      cursor_r       <= '0;
      next_free_r    <= {{NODE_W{1'b0}}, 1'b1};
      missed_r       <= 1'b0;
      overflow_r     <= 1'b0;
      live_r         <= 1'b0;
      last_r         <= 1'b0;
      clear_active_r <= 1'b1;
      clear_addr_r   <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cursor_r    <= cursor_nxt;
      next_free_r <= next_free_nxt;
      missed_r    <= missed_nxt;
      overflow_r  <= overflow_nxt;
      live_r      <= live_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
      if (clear_active_r) begin
        clear_addr_r <= clear_addr_r + {{(LINK_AW-1){1'b0}}, 1'b1};
        if (clear_addr_r == CLEAR_LAST) begin
          clear_active_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r    <= req_nxt;
    slot_r   <= slot_nxt;
    result_r <= result_nxt;
  end

  tde_ram #(
    .DEPTH (LINK_DEPTH),
    .WIDTH (NODE_W),
    .AW    (LINK_AW)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .re    (link_re),
    .raddr (slot_addr),
    .rdata (link_rdata)
  );

  tde_ram #(
    .DEPTH (NODE_COUNT),
    .WIDTH (1),
    .AW    (NODE_W)
  ) u_mark_ram (
    .clk   (clk),
    .we    (mark_we),
    .waddr (mark_waddr),
    .wdata (mark_wdata),
    .re    (mark_re),
    .raddr (mark_raddr),
    .rdata (mark_rdata)
  );

  assign out_valid      = out_valid_r;
  assign out_found      = result_r.found;
  assign out_table_full = result_r.table_full;

  `TDE_ASSERT_IMP(a_strobe_after_walk, out_valid_r, $past(state_r == S_LINK || state_r == S_MARK))
  `TDE_ASSERT_NEXT(a_strobe_single, out_valid_r, !out_valid_r)
  `TDE_ASSERT_NEXT(a_accept_reads_link, start && !busy, state_r == S_LINK)
  `TDE_ASSERT_ALWAYS(a_free_in_range, next_free_r <= NODE_LIMIT)
  `TDE_ASSERT_IMP(a_no_walk_while_clearing, clear_active_r, state_r == S_IDLE)

endmodule

/* tb/sv/trie_dictionary_engine_tb.sv */
// Self-checking testbench of the trie dictionary engine: letter stream against a trie predictor.
module trie_dictionary_engine_tb;
  import tde_pkg::*;

  localparam int NODES = 1024;
  localparam int ALPHA = 26;
  localparam int MAX_LEN = 40;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  typedef logic [LETTER_W-1:0] letter_t;

  typedef struct packed {
    logic [REQ_W-1:0] req;
    letter_t          ch;
    logic             last;
  } letter_xfer_t;

  typedef struct packed {
    logic [5:0]                len;
    letter_t [MAX_LEN-1:0]     ch;
  } word_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic [REQ_W-1:0] in_req_type = '0;
  letter_t          in_letter = '0;
  logic             in_last_letter = 1'b0;
  logic             out_valid;
  logic             out_found;
  logic             out_table_full;

  trie_dictionary_engine dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_req_type    (in_req_type),
    .in_letter      (in_letter),
    .in_last_letter (in_last_letter),
    .out_valid      (out_valid),
    .out_found      (out_found),
    .out_table_full (out_table_full)
  );

  letter_xfer_t pending_letters[$];
  tde_result_t  expected_results[$];
  word_t        stored_words[$];

  int unsigned queued_count = 0;
  int unsigned accepted_count = 0;
  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned idle_left = 0;
  bit          no_idle = 1'b0;
  logic        took_item = 1'b0;

  // Predictor copy of the trie.
  logic [9:0]  link_tab [0:NODES*ALPHA-1];
  bit          word_end [0:NODES-1];
  int unsigned free_node;
  logic [9:0]  cursor;
  bit          walk_miss;
  bit          walk_full;

  task automatic trie_clear();
    for (int i = 0; i < NODES*ALPHA; i++) link_tab[i] = '0;
    for (int i = 0; i < NODES; i++) word_end[i] = 1'b0;
    free_node = 1;
    cursor = '0;
    walk_miss = 1'b0;
    walk_full = 1'b0;
  endtask

  task automatic trie_walk(input logic [REQ_W-1:0] req, input letter_t ch, input logic last);
    int unsigned slot;
    logic [9:0]  child;
    tde_result_t res;
    res = '0;
    if (!walk_miss && !walk_full) begin
      if (req > REQ_PREFIX || ch >= ALPHA) begin
        walk_miss = 1'b1;
      end else begin
        slot = cursor * ALPHA + ch;
        child = link_tab[slot];
        if (child == '0 && req == REQ_INSERT) begin
          if (free_node < NODES) begin
            child = free_node[9:0];
            free_node++;
            link_tab[slot] = child;
          end else begin
            walk_full = 1'b1;
          end
        end
        if (!walk_full) begin
          if (child == '0) begin
            walk_miss = 1'b1;
          end else begin
            cursor = child;
            if (last) begin
              case (req)
                REQ_INSERT: begin
                  word_end[child] = 1'b1;
                  res.found = 1'b1;
                end
                REQ_SEARCH: res.found = word_end[child];
                default: res.found = 1'b1;
              endcase
            end
          end
        end
      end
    end
    if (last) begin
      res.table_full = (req == REQ_INSERT) && walk_full;
      if (walk_miss || walk_full) res.found = 1'b0;
      expected_results.push_back(res);
      cursor = '0;
      walk_miss = 1'b0;
      walk_full = 1'b0;
    end
  endtask

  task automatic push_item(input logic [REQ_W-1:0] req, input letter_t ch, input logic last);
    letter_xfer_t x;
    x.req = req;
    x.ch = ch;
    x.last = last;
    pending_letters.push_back(x);
    queued_count++;
  endtask

  task automatic send_word(input logic [REQ_W-1:0] req, input word_t w, input int unsigned n);
    for (int unsigned i = 0; i < n; i++) push_item(req, w.ch[i], i == n - 1);
  endtask

  function automatic word_t rand_word(input int unsigned lo, input int unsigned hi);
    word_t w;
    w = '0;
    w.len = 6'($urandom_range(lo, hi));
    for (int i = 0; i < MAX_LEN; i++) w.ch[i] = letter_t'($urandom_range(0, ALPHA - 1));
    return w;
  endfunction

  task automatic wait_drained();
    while (accepted_count != queued_count) @(negedge clk);
  endtask

  task automatic run_mixed(input int unsigned n_items);
    int unsigned base;
    int unsigned r;
    int unsigned n;
    word_t       w;
    base = queued_count;
    while (queued_count - base < n_items) begin
      r = $urandom_range(0, 99);
      if (stored_words.size() == 0) r = 0;
      if (r < 35) begin
        w = rand_word(1, 8);
        if ($urandom_range(0, 9) == 0) begin
          // A letter beyond z spoils the insert, so the word is not remembered.
          w.ch[$urandom_range(0, w.len - 1)] = letter_t'($urandom_range(ALPHA, 31));
        end else begin
          stored_words.push_back(w);
        end
        send_word(REQ_INSERT, w, w.len);
      end else if (r < 60) begin
        w = stored_words[$urandom_range(0, stored_words.size() - 1)];
        send_word(REQ_SEARCH, w, w.len);
      end else if (r < 75) begin
        w = stored_words[$urandom_range(0, stored_words.size() - 1)];
        n = $urandom_range(1, w.len);
        send_word($urandom_range(0, 1) ? REQ_PREFIX : REQ_SEARCH, w, n);
      end else if (r < 85) begin
        w = rand_word(1, 6);
        send_word($urandom_range(0, 1) ? REQ_PREFIX : REQ_SEARCH, w, w.len);
      end else if (r < 92) begin
        // Every letter of a known word with its own operation code.
        w = stored_words[$urandom_range(0, stored_words.size() - 1)];
        for (int unsigned i = 0; i < w.len; i++) begin
          push_item(($urandom_range(0, 15) == 0) ? REQ_UNUSED
                      : logic'(0) | REQ_W'($urandom_range(0, 2)),
                    w.ch[i], i == w.len - 1);
        end
      end else begin
        n = $urandom_range(1, 5);
        for (int unsigned i = 0; i < n; i++) begin
          push_item(REQ_W'($urandom_range(0, 3)), letter_t'($urandom_range(0, 31)),
                    (i == n - 1) || ($urandom_range(0, 2) == 0));
        end
      end
    end
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin : stimulus
    word_t w;
    trie_clear();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Extreme letters, exact word against its own prefix.
    push_item(REQ_INSERT, 5'd25, 1'b0);
    push_item(REQ_INSERT, 5'd0, 1'b0);
    push_item(REQ_INSERT, 5'd25, 1'b1);
    push_item(REQ_SEARCH, 5'd25, 1'b0);
    push_item(REQ_SEARCH, 5'd0, 1'b0);
    push_item(REQ_SEARCH, 5'd25, 1'b1);
    push_item(REQ_SEARCH, 5'd25, 1'b0);
    push_item(REQ_SEARCH, 5'd0, 1'b1);
    push_item(REQ_PREFIX, 5'd25, 1'b0);
    push_item(REQ_PREFIX, 5'd0, 1'b1);
    // A miss stops the walk; the remaining letters are ignored.
    push_item(REQ_SEARCH, 5'd1, 1'b1);
    push_item(REQ_PREFIX, 5'd2, 1'b0);
    push_item(REQ_PREFIX, 5'd25, 1'b1);
    // Letters beyond z, and the unused operation code.
    push_item(REQ_INSERT, 5'd26, 1'b1);
    push_item(REQ_INSERT, 5'd0, 1'b0);
    push_item(REQ_INSERT, 5'd31, 1'b1);
    push_item(REQ_UNUSED, 5'd5, 1'b1);
    // Mixed operation codes inside one word.
    push_item(REQ_INSERT, 5'd1, 1'b0);
    push_item(REQ_INSERT, 5'd2, 1'b1);
    push_item(REQ_PREFIX, 5'd1, 1'b0);
    push_item(REQ_SEARCH, 5'd2, 1'b1);
    push_item(REQ_SEARCH, 5'd1, 1'b0);
    push_item(REQ_INSERT, 5'd3, 1'b1);
    push_item(REQ_UNUSED, 5'd1, 1'b0);
    push_item(REQ_SEARCH, 5'd2, 1'b1);

    run_mixed(100);

    // Long fresh words use up the node table.
    while (free_node < NODES) begin
      w = rand_word(20, MAX_LEN);
      stored_words.push_back(w);
      send_word(REQ_INSERT, w, w.len);
      wait_drained();
    end
    for (int i = 0; i < 8; i++) begin
      w = rand_word(2, 6);
      send_word(REQ_INSERT, w, w.len);
    end
    w = stored_words[$urandom_range(0, stored_words.size() - 1)];
    send_word(REQ_INSERT, w, w.len);

    run_mixed(50);

    wait_drained();
    while (expected_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (err_cnt == 0) begin
      $display("** trie_dictionary_engine: PASSED **");
    end else begin
      $display("** trie_dictionary_engine: FAILED **");
    end
    $finish;
  end

  // A held item stays on the ports until its transfer; gaps are drawn after each transfer.
  always @(negedge clk) begin : driver
    letter_xfer_t nxt;
    if (rst_n && !(start && !took_item)) begin
      if (start) begin
        if ($urandom_range(0, 63) == 0) no_idle = !no_idle;
        idle_left = no_idle ? 0 : $urandom_range(0, 4);
      end
      if (idle_left > 0) begin
        idle_left--;
        start <= 1'b0;
      end else if (pending_letters.size() > 0) begin
        nxt = pending_letters.pop_front();
        in_req_type <= nxt.req;
        in_letter <= nxt.ch;
        in_last_letter <= nxt.last;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : monitor
    tde_result_t want;
    if (!rst_n) begin
      took_item <= 1'b0;
    end else begin
      took_item <= start && !busy;
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual found=%0b table_full=%0b",
                   $time, out_found, out_table_full);
          err_cnt++;
        end else begin
          want = expected_results.pop_front();
          if (out_found !== want.found) begin
            $display("%0t: found mismatch, expected %0b, actual %0b",
                     $time, want.found, out_found);
            err_cnt++;
          end
          if (out_table_full !== want.table_full) begin
            $display("%0t: table_full mismatch, expected %0b, actual %0b",
                     $time, want.table_full, out_table_full);
            err_cnt++;
          end
        end
      end
      if (start && !busy) begin
        trie_walk(in_req_type, in_letter, in_last_letter);
        accepted_count++;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still expected", $time, expected_results.size());
      $display("** trie_dictionary_engine: FAILED **");
      $finish;
    end
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/tde_pkg.sv
rtl/tde_ram.sv
rtl/trie_dictionary_engine.sv
tb/sv/trie_dictionary_engine_tb.sv
